// ===== src/direct_mapped_cache_trace_model_unit_macros.svh =====
// Assertion macros for the direct-mapped cache model checker
`ifndef DIRECT_MAPPED_CACHE_TRACE_MODEL_UNIT_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TRACE_MODEL_UNIT_MACROS_SVH

// same-cycle implication
`define DMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cache port check failed");

// next-cycle implication
`define DMC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cache port check failed");

`endif

// ===== src/dmc_pkg.sv =====
// Shared types and constants for the direct-mapped cache model
`default_nettype none
package dmc_pkg;

  localparam int unsigned ADDR_W          = 30;
  localparam int unsigned RW_W            = 9;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned LL_W            = 4;
  localparam int unsigned LL_MAX          = 8;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 4;
  localparam int unsigned CACHE_CELLS_DEF = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSTR   = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_WMISS   = 2'd2,
    MODE_NOALLOC = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 1'b0,
    CFG_LINE = 1'b1
  } cfg_idx_e;

  // access class decided by the front end
  typedef enum logic [2:0] {
    K_CLEAR     = 3'd0,
    K_BYPASS    = 3'd1,
    K_FILL      = 3'd2,
    K_WR_ALWAYS = 3'd3,
    K_WR_MISS   = 3'd4,
    K_WR_NONE   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              is_write;
    logic [LL_W-1:0]   ll;
    logic [ADDR_W-1:0] addr;
  } dmc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dmc_qstat_t;

endpackage
`default_nettype wire

// ===== src/dmc_queue.sv =====
// Two-word queue between the classifying front end and the lookup back end
`default_nettype none
module dmc_queue import dmc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire dmc_item_t  item_i,
  input  wire logic       pop_i,
  output dmc_item_t       item_o,
  output dmc_qstat_t      stat_o
);

  localparam int unsigned QD = 2;

  dmc_item_t  ent_q [QD];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'(QD));
  assign stat_o.empty = (cnt_q == 2'd0);
  assign item_o       = ent_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i  ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/dmc_front.sv =====
// Front end: configuration registers, input handshake and access classification
`default_nettype none
module dmc_front import dmc_pkg::*; #(
  parameter int unsigned CACHE_CELLS = CACHE_CELLS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic                  is_data_i,
  input  wire logic                  is_write_i,
  input  wire logic [ADDR_W-1:0]     address_i,
  input  wire dmc_qstat_t            q_stat_i,
  input  wire logic                  clr_busy_i,
  output logic                       push_o,
  output dmc_item_t                  item_o
);

  localparam int unsigned CLOG   = $clog2(CACHE_CELLS);
  localparam int unsigned LL_CAP = (CLOG < LL_MAX) ? CLOG : LL_MAX;

  mode_e           mode_q, mode_d;
  logic [LL_W-1:0] line_q, line_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    line_d = line_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE: mode_d = mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_LINE: line_d = cfg_data_i[LL_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INSTR;
      line_q <= '0;
    end else begin
      mode_q <= mode_d;
      line_q <= line_d;
    end
  end

  assign in_stall_o = q_stat_i.full || clr_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    item_o.is_write = is_write_i;
    item_o.addr     = address_i;
    item_o.ll       = (32'(line_q) > LL_CAP) ? LL_W'(LL_CAP) : line_q;
    if (op_i) begin
      item_o.kind = K_CLEAR;
    end else if (mode_q == MODE_INSTR && is_data_i) begin
      item_o.kind = K_BYPASS;
    end else if (mode_q == MODE_INSTR || !is_write_i) begin
      item_o.kind = K_FILL;
    end else begin
      case (mode_q)
        MODE_ALLOC: item_o.kind = K_WR_ALWAYS;
        MODE_WMISS: item_o.kind = K_WR_MISS;
        default:    item_o.kind = K_WR_NONE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/dmc_back.sv =====
// Back end: tag RAM lookup with forwarding, allocation, counters and output register
`default_nettype none
module dmc_back import dmc_pkg::*; #(
  parameter int unsigned CACHE_CELLS = CACHE_CELLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dmc_qstat_t        q_stat_i,
  input  wire dmc_item_t         q_item_i,
  output logic                   pop_o,
  output logic                   clr_busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   missed_o,
  output logic [RW_W-1:0]        read_words_o,
  output logic                   write_words_o,
  output logic [CNT_W-1:0]       access_count_o,
  output logic [CNT_W-1:0]       stall_count_o,
  output logic [CNT_W-1:0]       miss_count_o,
  output logic [CNT_W-1:0]       read_count_o,
  output logic [CNT_W-1:0]       write_count_o
);

  localparam int unsigned CLOG  = $clog2(CACHE_CELLS);
  localparam int unsigned TAG_W = ADDR_W - CLOG;
  localparam int unsigned ENT_W = TAG_W + 1;

  // entry = {valid, tag}
  logic [ENT_W-1:0] tag_mem_q [CACHE_CELLS];

  logic             clr_busy_q, clr_busy_d;
  logic [CLOG-1:0]  clr_idx_q, clr_idx_d;

  logic             s1_vld_q, s1_vld_d;
  dmc_item_t        s1_item_q;
  logic [ENT_W-1:0] rd_ent_q;
  logic             fwd_q, fwd_d;
  logic [ENT_W-1:0] fwd_ent_q;

  logic             out_vld_q, out_vld_d;
  logic             missed_q;
  logic [RW_W-1:0]  rw_q;
  logic             ww_q;

  logic [CNT_W-1:0] acc_q, acc_d, stl_q, stl_d, mis_q, mis_d, rdc_q, rdc_d, wrc_q, wrc_d;

  logic [CLOG-1:0]  pop_idx, s1_idx;
  logic [TAG_W-1:0] s1_tag;
  logic [ENT_W-1:0] ent, wr_ent;
  logic [RW_W-1:0]  lsize;
  logic             hit, s1_adv, pop, alloc;
  logic             c_miss, c_wr, c_stall;
  logic [RW_W-1:0]  c_rd;

  assign pop_idx = CLOG'(q_item_i.addr[CLOG-1:0] >> q_item_i.ll);
  assign s1_idx  = CLOG'(s1_item_q.addr[CLOG-1:0] >> s1_item_q.ll);
  assign s1_tag  = s1_item_q.addr[ADDR_W-1:CLOG];
  assign lsize   = RW_W'(1) << s1_item_q.ll;
  assign ent     = fwd_q ? fwd_ent_q : rd_ent_q;
  assign hit     = ent[TAG_W] && (ent[TAG_W-1:0] == s1_tag);
  assign wr_ent  = {1'b1, s1_tag};

  assign s1_adv  = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign pop     = !q_stat_i.empty && !clr_busy_q && (!s1_vld_q || s1_adv);
  assign pop_o   = pop;

  always_comb begin
    c_miss  = 1'b0;
    c_rd    = '0;
    c_wr    = 1'b0;
    c_stall = 1'b0;
    alloc   = 1'b0;
    case (s1_item_q.kind)
      K_BYPASS: begin
        c_miss = 1'b1;
        c_wr   = s1_item_q.is_write;
        c_rd   = RW_W'(!s1_item_q.is_write);
      end
      K_FILL: begin
        c_miss = !hit;
        alloc  = !hit;
        c_rd   = (!hit && !s1_item_q.is_write) ? lsize : '0;
      end
      K_WR_ALWAYS: begin
        c_miss = !hit;
        c_wr   = 1'b1;
        c_rd   = lsize - RW_W'(1);
        alloc  = 1'b1;
      end
      K_WR_MISS: begin
        c_miss  = !hit;
        c_wr    = 1'b1;
        c_stall = 1'b1;
        c_rd    = hit ? '0 : lsize - RW_W'(1);
        alloc   = !hit;
      end
      K_WR_NONE: begin
        c_miss = !hit;
        c_wr   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    stl_d = stl_q;
    mis_d = mis_q;
    rdc_d = rdc_q;
    wrc_d = wrc_q;
    if (s1_adv) begin
      if (s1_item_q.kind == K_CLEAR) begin
        acc_d = '0;
        stl_d = '0;
        mis_d = '0;
        rdc_d = '0;
        wrc_d = '0;
      end else begin
        acc_d = acc_q + CNT_W'(1);
        stl_d = stl_q + CNT_W'(c_stall);
        mis_d = mis_q + CNT_W'(c_miss);
        rdc_d = rdc_q + CNT_W'(c_rd);
        wrc_d = wrc_q + CNT_W'(c_wr);
      end
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + CLOG'(1);
      if (clr_idx_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_vld_d  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_q);
    fwd_d     = pop ? (s1_adv && alloc && s1_idx == pop_idx) : fwd_q;
    out_vld_d = s1_adv ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      s1_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      acc_q      <= '0;
      stl_q      <= '0;
      mis_q      <= '0;
      rdc_q      <= '0;
      wrc_q      <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
      s1_vld_q   <= s1_vld_d;
      fwd_q      <= fwd_d;
      out_vld_q  <= out_vld_d;
      acc_q      <= acc_d;
      stl_q      <= stl_d;
      mis_q      <= mis_d;
      rdc_q      <= rdc_d;
      wrc_q      <= wrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tag_mem_q[clr_idx_q] <= '0;
    end else if (s1_adv && alloc) begin
      tag_mem_q[s1_idx] <= wr_ent;
    end
    if (pop) begin
      rd_ent_q <= tag_mem_q[pop_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q <= q_item_i;
      fwd_ent_q <= wr_ent;
    end
    if (s1_adv) begin
      missed_q <= c_miss;
      rw_q     <= c_rd;
      ww_q     <= c_wr;
    end
  end

  assign clr_busy_o     = clr_busy_q;
  assign out_valid_o    = out_vld_q;
  assign missed_o       = missed_q;
  assign read_words_o   = rw_q;
  assign write_words_o  = ww_q;
  assign access_count_o = acc_q;
  assign stall_count_o  = stl_q;
  assign miss_count_o   = mis_q;
  assign read_count_o   = rdc_q;
  assign write_count_o  = wrc_q;

endmodule
`default_nettype wire

// ===== src/direct_mapped_cache_trace_model_unit.sv =====
// Top level of the direct-mapped write-through cache model with statistics counters.
// Path: an accepted input word passes the queue, the lookup stage and the output register.
// Throughput: one word per cycle unless stalled, via the tag RAM's read, write and forwarding.
// Reset: counters and config registers clear; the tag RAM, valid bits included, is then swept,
// one entry a cycle, with in_stall_o held high throughout.
`default_nettype none
module direct_mapped_cache_trace_model_unit import dmc_pkg::*; #(
  parameter int unsigned CACHE_CELLS = CACHE_CELLS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic                  is_data_i,
  input  wire logic                  is_write_i,
  input  wire logic [ADDR_W-1:0]     address_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       missed_o,
  output logic [RW_W-1:0]            read_words_o,
  output logic                       write_words_o,
  output logic [CNT_W-1:0]           access_count_o,
  output logic [CNT_W-1:0]           stall_count_o,
  output logic [CNT_W-1:0]           miss_count_o,
  output logic [CNT_W-1:0]           read_count_o,
  output logic [CNT_W-1:0]           write_count_o
);

  dmc_qstat_t q_stat;
  dmc_item_t  push_item, pop_item;
  logic       push, pop, clr_busy;

  dmc_front #(
    .CACHE_CELLS(CACHE_CELLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .is_data_i  (is_data_i),
    .is_write_i (is_write_i),
    .address_i  (address_i),
    .q_stat_i   (q_stat),
    .clr_busy_i (clr_busy),
    .push_o     (push),
    .item_o     (push_item)
  );

  dmc_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(push_item),
    .pop_i (pop),
    .item_o(pop_item),
    .stat_o(q_stat)
  );

  dmc_back #(
    .CACHE_CELLS(CACHE_CELLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_item_i      (pop_item),
    .pop_o         (pop),
    .clr_busy_o    (clr_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .missed_o      (missed_o),
    .read_words_o  (read_words_o),
    .write_words_o (write_words_o),
    .access_count_o(access_count_o),
    .stall_count_o (stall_count_o),
    .miss_count_o  (miss_count_o),
    .read_count_o  (read_count_o),
    .write_count_o (write_count_o)
  );

endmodule
`default_nettype wire

// ===== src/dmc_checker.sv =====
// Port-level assertion checker for the cache model, bound to the top level
`default_nettype none
`include "direct_mapped_cache_trace_model_unit_macros.svh"
module dmc_checker import dmc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_stall_i,
  input wire logic             missed_i,
  input wire logic [RW_W-1:0]  read_words_i,
  input wire logic             write_words_i,
  input wire logic [CNT_W-1:0] access_count_i
);

  `DMC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)
  `DMC_ASSERT_NXT(a_out_steady, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(missed_i) && $stable(read_words_i) && $stable(access_count_i))
  `DMC_ASSERT_IMP(a_hit_no_fill, clk_i, rst_ni, out_valid_i && !missed_i && !write_words_i, read_words_i == '0)
  `DMC_ASSERT_IMP(a_write_fill_cap, clk_i, rst_ni, out_valid_i && write_words_i, !read_words_i[RW_W-1])

endmodule

bind direct_mapped_cache_trace_model_unit dmc_checker u_dmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .missed_i      (missed_o),
  .read_words_i  (read_words_o),
  .write_words_i (write_words_o),
  .access_count_i(access_count_o)
);
`default_nettype wire

// ===== tb/direct_mapped_cache_trace_model_unit_test.sv =====
// Testbench for the direct-mapped cache model: predicts every result word and checks it
`timescale 1ns / 100ps

typedef struct {
  logic                       missed;
  logic [dmc_pkg::RW_W-1:0]   read_words;
  logic                       write_words;
  logic [dmc_pkg::CNT_W-1:0]  access_count;
  logic [dmc_pkg::CNT_W-1:0]  stall_count;
  logic [dmc_pkg::CNT_W-1:0]  miss_count;
  logic [dmc_pkg::CNT_W-1:0]  read_count;
  logic [dmc_pkg::CNT_W-1:0]  write_count;
} cache_outcome_t;

class cache_ledger;
  dmc_pkg::mode_e              mode;
  logic [dmc_pkg::LL_W-1:0]    line_sel;
  logic [21:0]                 tags [256];
  bit                          valid [256];
  logic [dmc_pkg::CNT_W-1:0]   accesses, stalls, misses, reads_out, writes_out;
  cache_outcome_t              pending_outcomes [$];
  int                          errors;

  function new();
    mode = dmc_pkg::MODE_INSTR;
    line_sel = '0;
    foreach (valid[i]) valid[i] = 1'b0;
    foreach (tags[i]) tags[i] = '0;
    accesses = '0;
    stalls = '0;
    misses = '0;
    reads_out = '0;
    writes_out = '0;
    errors = 0;
  endfunction

  function void set_reg(dmc_pkg::cfg_idx_e idx, logic [dmc_pkg::CFG_DATA_W-1:0] val);
    if (idx == dmc_pkg::CFG_MODE) begin
      mode = dmc_pkg::mode_e'(val[1:0]);
    end else begin
      line_sel = val;
    end
  endfunction

  function void note_access(logic op, logic is_data, logic is_write,
                            logic [dmc_pkg::ADDR_W-1:0] addr);
    cache_outcome_t o;
    int unsigned ll;
    int unsigned idx;
    logic [21:0] tag;
    logic [dmc_pkg::RW_W-1:0] lsize;
    bit hit;
    o.missed = 1'b0;
    o.read_words = '0;
    o.write_words = 1'b0;
    if (op) begin
      accesses = '0;
      stalls = '0;
      misses = '0;
      reads_out = '0;
      writes_out = '0;
    end else begin
      ll = (line_sel > dmc_pkg::LL_MAX) ? dmc_pkg::LL_MAX : line_sel;
      lsize = 9'd1 << ll;
      idx = addr[7:0] >> ll;
      tag = addr[29:8];
      hit = valid[idx] && tags[idx] == tag;
      accesses++;
      if (mode == dmc_pkg::MODE_INSTR && is_data) begin
        o.missed = 1'b1;
        if (is_write) o.write_words = 1'b1;
        else o.read_words = 9'd1;
      end else if (mode == dmc_pkg::MODE_INSTR || !is_write) begin
        if (!hit) begin
          o.missed = 1'b1;
          if (!is_write) o.read_words = lsize;
          tags[idx] = tag;
          valid[idx] = 1'b1;
        end
      end else if (mode == dmc_pkg::MODE_ALLOC) begin
        o.missed = !hit;
        o.write_words = 1'b1;
        o.read_words = lsize - 9'd1;
        tags[idx] = tag;
        valid[idx] = 1'b1;
      end else if (mode == dmc_pkg::MODE_WMISS) begin
        o.write_words = 1'b1;
        stalls++;
        if (!hit) begin
          o.missed = 1'b1;
          o.read_words = lsize - 9'd1;
          tags[idx] = tag;
          valid[idx] = 1'b1;
        end
      end else begin
        o.write_words = 1'b1;
        o.missed = !hit;
      end
      misses += o.missed;
      reads_out += o.read_words;
      writes_out += o.write_words;
    end
    o.access_count = accesses;
    o.stall_count = stalls;
    o.miss_count = misses;
    o.read_count = reads_out;
    o.write_count = writes_out;
    pending_outcomes.push_back(o);
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_outcome(cache_outcome_t got);
    cache_outcome_t want;
    if (pending_outcomes.size() == 0) begin
      errors++;
      $display("%0t result word: expected none, actual access_count %0h",
               $time, got.access_count);
    end else begin
      want = pending_outcomes.pop_front();
      compare("missed", want.missed, got.missed);
      compare("read_words", want.read_words, got.read_words);
      compare("write_words", want.write_words, got.write_words);
      compare("access_count", want.access_count, got.access_count);
      compare("stall_count", want.stall_count, got.stall_count);
      compare("miss_count", want.miss_count, got.miss_count);
      compare("read_count", want.read_count, got.read_count);
      compare("write_count", want.write_count, got.write_count);
    end
  endfunction
endclass

module direct_mapped_cache_trace_model_unit_test;
  import dmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  op_i;
  logic                  is_data_i;
  logic                  is_write_i;
  logic [ADDR_W-1:0]     address_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  missed_o;
  logic [RW_W-1:0]       read_words_o;
  logic                  write_words_o;
  logic [CNT_W-1:0]      access_count_o;
  logic [CNT_W-1:0]      stall_count_o;
  logic [CNT_W-1:0]      miss_count_o;
  logic [CNT_W-1:0]      read_count_o;
  logic [CNT_W-1:0]      write_count_o;

  cache_ledger  board;
  bit           calm;
  int unsigned  cycles;

  direct_mapped_cache_trace_model_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .is_data_i      (is_data_i),
    .is_write_i     (is_write_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .missed_o       (missed_o),
    .read_words_o   (read_words_o),
    .write_words_o  (write_words_o),
    .access_count_o (access_count_o),
    .stall_count_o  (stall_count_o),
    .miss_count_o   (miss_count_o),
    .read_count_o   (read_count_o),
    .write_count_o  (write_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("direct_mapped_cache_trace_model_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cache_outcome_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.missed = missed_o;
      got.read_words = read_words_o;
      got.write_words = write_words_o;
      got.access_count = access_count_o;
      got.stall_count = stall_count_o;
      got.miss_count = miss_count_o;
      got.read_count = read_count_o;
      got.write_count = write_count_o;
      board.check_outcome(got);
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(logic op, logic is_data, logic is_write, logic [ADDR_W-1:0] addr);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    is_data_i <= is_data;
    is_write_i <= is_write;
    address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    board.note_access(op, is_data, is_write, addr);
  endtask

  task automatic access(logic is_data, logic is_write, logic [ADDR_W-1:0] addr);
    send_word(1'b0, is_data, is_write, addr);
  endtask

  // hold off until every expected word is back, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending_outcomes.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(mode_e m, logic [LL_W-1:0] ll);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = {2'($urandom_range(0, 3)), m};
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MODE;
    cfg_data_i <= mode_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(CFG_MODE, mode_word);
    cfg_index_i <= CFG_LINE;
    cfg_data_i <= ll;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(CFG_LINE, ll);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_word();
    logic [21:0] tag;
    case ($urandom_range(0, 9))
      0: tag = 22'($urandom);
      1: tag = 22'h3fffff;
      default: tag = 22'($urandom_range(0, 3));
    endcase
    send_word($urandom_range(0, 49) == 0, 1'($urandom), 1'($urandom),
              {tag, 8'($urandom_range(0, 255))});
  endtask

  initial begin
    mode_e fixed_mode [6];
    logic [LL_W-1:0] fixed_ll [6];
    mode_e pm;
    logic [LL_W-1:0] pl;
    fixed_mode = '{MODE_NOALLOC, MODE_INSTR, MODE_ALLOC, MODE_WMISS, MODE_ALLOC, MODE_INSTR};
    fixed_ll = '{4'd15, 4'd0, 4'd8, 4'd0, 4'd15, 4'd9};
    board = new();
    calm = 1'b0;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = 1'b0;
    is_data_i = 1'b0;
    is_write_i = 1'b0;
    address_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // instruction-only cache, one-cell lines
    set_config(MODE_INSTR, 4'd0);
    access(1'b0, 1'b0, 30'h0);
    access(1'b0, 1'b0, 30'h0);
    access(1'b0, 1'b1, 30'h3fffffff);
    access(1'b0, 1'b0, 30'h3fffffff);
    access(1'b1, 1'b0, 30'h3fffffff);
    access(1'b1, 1'b1, 30'h0);
    send_word(1'b1, 1'b1, 1'b1, 30'h3fffffff);
    // always allocate, largest line
    set_config(MODE_ALLOC, 4'd8);
    access(1'b1, 1'b1, 30'h155);
    access(1'b1, 1'b1, 30'h155);
    access(1'b1, 1'b0, 30'h155);
    access(1'b0, 1'b0, 30'h3fffffff);
    // allocate on write miss, oversize line clamps
    set_config(MODE_WMISS, 4'd15);
    access(1'b1, 1'b1, 30'h3fffffff);
    access(1'b0, 1'b1, 30'h0);
    access(1'b0, 1'b0, 30'h0);
    // never allocate on write
    set_config(MODE_NOALLOC, 4'd4);
    access(1'b1, 1'b1, 30'h2aaaaaaa);
    access(1'b1, 1'b1, 30'h2aaaaaaa);
    access(1'b0, 1'b0, 30'h2aaaaaaa);
    access(1'b0, 1'b1, 30'h2aaaaaaa);
    send_word(1'b1, 1'b0, 1'b0, 30'h0);

    for (int p = 0; p < 10; p++) begin
      if (p < 6) begin
        pm = fixed_mode[p];
        pl = fixed_ll[p];
      end else begin
        pm = mode_e'($urandom_range(0, 3));
        pl = LL_W'($urandom_range(0, 15));
      end
      set_config(pm, pl);
      if (p == 9) calm = 1'b1;
      for (int k = 0; k < 100; k++) random_word();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("direct_mapped_cache_trace_model_unit: match");
    end else begin
      $display("direct_mapped_cache_trace_model_unit: mismatch");
    end
    $finish;
  end
endmodule
